FILE: src/pkd_pkg.sv
// ============================================================================
// pkd_pkg: shared types and constants for the PK packed-number decoder
// Token and packet structs, decoder state and phase codes.
// ============================================================================
package pkd_pkg;

  // Width of the largest value that a token may carry before it saturates
  localparam int VALUE_BITS = 32;
  localparam int TOKEN_W    = 32;
  localparam logic [TOKEN_W-1:0] VALUE_LIMIT =
    (VALUE_BITS >= 32) ? {TOKEN_W{1'b1}} : TOKEN_W'((64'd1 << VALUE_BITS) - 64'd1);

  // Long-number accumulator: holds the clamp value 2^36
  localparam int ACC_W = 37;
  localparam logic [ACC_W-1:0] ACC_CAP = ACC_W'(1) << 36;

  // Nybble codes
  localparam logic [3:0] NYB_ZERO    = 4'd0;
  localparam logic [3:0] DYN_MAX     = 4'd13;
  localparam logic [3:0] NYB_REPEAT  = 4'd14;
  localparam logic [3:0] NYB_REP_ONE = 4'd15;

  // Token kinds
  localparam logic KIND_RUN    = 1'b0;
  localparam logic KIND_REPEAT = 1'b1;

  // Decoder phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_ZEROS  = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_LONG2  = 2'd3;

  // Configuration register indexes
  localparam logic CFG_DYN_FACTOR  = 1'b0;
  localparam logic CFG_START_BLACK = 1'b1;

  typedef struct packed {
    logic [1:0]       phase;
    logic [3:0]       zero_cnt;
    logic [ACC_W-1:0] acc;
    logic [3:0]       lead;
    logic             rep_pend;
    logic             color;
  } dec_state_t;

  typedef struct packed {
    logic               kind;
    logic [TOKEN_W-1:0] value;
    logic               color;
    logic               err;
    logic               last;
  } token_t;

  // One accepted byte's worth of tokens (at least one)
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } pkt_t;

endpackage

FILE: src/pk_packed_number_decoder_core.sv
// ============================================================================
// pk_packed_number_decoder_core: PK font packed-raster token decoder
// Decodes dyn_f packed numbers from raster bytes into run and repeat tokens.
// ============================================================================
// A byte beat is taken every cycle while the two-packet queue has room; both
// nybbles of the byte are decoded in that cycle. The output side sends one
// token beat per cycle while m_tready_i is high, so a byte that yields two
// tokens holds the output for two beats and a byte that yields none pushes
// no packet. A token passes a queue entry, then the output register, before
// it is valid on the master side. Configuration writes take effect on the next
// byte; start_black is loaded at reset and at each glyph_start beat.
module pk_packed_number_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [3:0]  cfg_wdata_i,
  // byte stream in
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [7:0] data_byte
  input  logic        s_tuser_i,   // [0] glyph_start
  // token stream out
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [39:0] m_tdata_o,   // [31:0] token_value, [32] run_color,
                                   // [33] decode_error, [39:34] zero
  output logic        m_tuser_o,   // [0] token_kind
  output logic        m_tlast_o    // last_of_byte
);
  import pkd_pkg::*;

  logic [3:0] dyn_factor_q;
  logic       start_black_q;
  logic       q_full, q_push, q_pop, q_vld;
  pkt_t       front_pkt, head_pkt;
  token_t     tok;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dyn_factor_q  <= 4'd0;
      start_black_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DYN_FACTOR:  dyn_factor_q  <= cfg_wdata_i;
        CFG_START_BLACK: start_black_q <= cfg_wdata_i[0];
        default:         dyn_factor_q  <= dyn_factor_q;
      endcase
    end
  end

  pkd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_vld_i     (s_tvalid_i),
    .in_rdy_o     (s_tready_o),
    .data_byte_i  (s_tdata_i),
    .glyph_start_i(s_tuser_i),
    .dyn_factor_i (dyn_factor_q),
    .start_black_i(start_black_q),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_pkt_o      (front_pkt)
  );

  pkd_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(q_push),
    .pkt_i (front_pkt),
    .full_o(q_full),
    .pop_i (q_pop),
    .vld_o (q_vld),
    .pkt_o (head_pkt)
  );

  pkd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_vld_i  (q_vld),
    .q_pkt_i  (head_pkt),
    .q_pop_o  (q_pop),
    .out_vld_o(m_tvalid_o),
    .out_rdy_i(m_tready_i),
    .out_tok_o(tok)
  );

  // Output beat packing
  assign m_tdata_o = {6'd0, tok.err, tok.color, tok.value};
  assign m_tuser_o = tok.kind;
  assign m_tlast_o = tok.last;

endmodule

FILE: src/pkd_nybble.sv
// ============================================================================
// pkd_nybble: one nybble step of the packed-number decoder
// Combinational: takes the decoder state and a nybble, returns the next
// state and at most one token.
// ============================================================================
module pkd_nybble (
  input  pkd_pkg::dec_state_t state_i,
  input  logic [3:0]          nyb_i,
  input  logic [3:0]          dyn_i,   // already clamped to 13
  output pkd_pkg::dec_state_t state_o,
  output logic                tok_vld_o,
  output pkd_pkg::token_t     tok_o
);
  import pkd_pkg::*;

  logic [ACC_W+3:0]   acc_sh;
  logic [ACC_W-1:0]   acc_new;
  logic [3:0]         zc_new;
  logic [7:0]         bias;
  logic [ACC_W-1:0]   sum;
  logic [TOKEN_W-1:0] lead_diff;
  logic [ACC_W-1:0]   long2_val;
  logic               fin_en;
  logic [ACC_W-1:0]   fin_val;
  logic               sat;

  // Datapath pieces for the long forms
  always_comb begin
    acc_sh    = {state_i.acc, nyb_i};
    acc_new   = (acc_sh > (ACC_W+4)'(ACC_CAP)) ? ACC_CAP : acc_sh[ACC_W-1:0];
    zc_new    = (state_i.zero_cnt != 4'd0) ? state_i.zero_cnt - 4'd1 : 4'd0;
    bias      = {DYN_MAX - dyn_i, 4'd0} + {4'd0, dyn_i};
    sum       = acc_new + ACC_W'(bias);
    // lead difference wraps at 32 bits (dyn_f raised in mid token);
    // the scaled value is kept wide so that it saturates
    lead_diff = TOKEN_W'(state_i.lead) - TOKEN_W'(dyn_i) - TOKEN_W'(1);
    long2_val = {1'b0, lead_diff, 4'd0} + ACC_W'(nyb_i)
              + ACC_W'(dyn_i) + ACC_W'(1);
  end

  // Phase handling
  always_comb begin
    state_o   = state_i;
    tok_vld_o = 1'b0;
    tok_o     = '0;
    fin_en    = 1'b0;
    fin_val   = '0;
    sat       = 1'b0;

    case (state_i.phase)
      PH_ZEROS: begin
        if (nyb_i == NYB_ZERO) begin
          if (state_i.zero_cnt != 4'd15) state_o.zero_cnt = state_i.zero_cnt + 4'd1;
        end else begin
          state_o.acc   = ACC_W'(nyb_i);
          state_o.phase = PH_DIGITS;
        end
      end
      PH_DIGITS: begin
        state_o.zero_cnt = zc_new;
        if (zc_new == 4'd0) begin
          state_o.phase = PH_IDLE;
          state_o.acc   = '0;
          fin_en        = 1'b1;
          fin_val       = (sum >= ACC_W'(15)) ? sum - ACC_W'(15) : '0;
        end else begin
          state_o.acc = acc_new;
        end
      end
      PH_LONG2: begin
        state_o.phase = PH_IDLE;
        fin_en        = 1'b1;
        fin_val       = long2_val;
      end
      default: begin
        state_o.phase = PH_IDLE;
        if (nyb_i == NYB_ZERO) begin
          state_o.zero_cnt = 4'd1;
          state_o.acc      = '0;
          state_o.phase    = PH_ZEROS;
        end else if (nyb_i <= dyn_i) begin
          fin_en  = 1'b1;
          fin_val = ACC_W'(nyb_i);
        end else if (nyb_i < NYB_REPEAT) begin
          state_o.lead  = nyb_i;
          state_o.phase = PH_LONG2;
        end else if (nyb_i == NYB_REPEAT) begin
          if (state_i.rep_pend) begin
            // nested repeat marker: flagged zero count, repeat stays pending
            tok_vld_o  = 1'b1;
            tok_o.kind = KIND_REPEAT;
            tok_o.err  = 1'b1;
          end else begin
            state_o.rep_pend = 1'b1;
          end
        end else begin
          // repeat once; flagged when a count was pending
          tok_vld_o        = 1'b1;
          tok_o.kind       = KIND_REPEAT;
          tok_o.value      = TOKEN_W'(1);
          tok_o.err        = state_i.rep_pend;
          state_o.rep_pend = 1'b0;
        end
      end
    endcase

    // Finished number: repeat count if one is pending, else a run
    if (fin_en) begin
      sat       = fin_val > ACC_W'(VALUE_LIMIT);
      tok_vld_o = 1'b1;
      tok_o.value = sat ? VALUE_LIMIT : fin_val[TOKEN_W-1:0];
      tok_o.err   = sat;
      if (state_i.rep_pend) begin
        tok_o.kind       = KIND_REPEAT;
        state_o.rep_pend = 1'b0;
      end else begin
        tok_o.kind    = KIND_RUN;
        tok_o.color   = state_i.color;
        state_o.color = ~state_i.color;
      end
    end
  end

endmodule

FILE: src/pkd_front.sv
// ============================================================================
// pkd_front: byte intake and token classification
// Holds the decoder state, decodes both nybbles of a byte per beat and
// pushes the resulting tokens as one packet into the queue.
// ============================================================================
module pkd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_vld_i,
  output logic            in_rdy_o,
  input  logic [7:0]      data_byte_i,
  input  logic            glyph_start_i,
  input  logic [3:0]      dyn_factor_i,
  input  logic            start_black_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output pkd_pkg::pkt_t   q_pkt_o
);
  import pkd_pkg::*;

  dec_state_t st_q, st_d;
  dec_state_t cur, mid;
  logic [3:0] dyn_eff;
  logic       vld_hi, vld_lo;
  token_t     tok_hi, tok_lo;
  logic       accept;

  assign dyn_eff  = (dyn_factor_i > DYN_MAX) ? DYN_MAX : dyn_factor_i;
  assign in_rdy_o = ~q_full_i;
  assign accept   = in_vld_i & ~q_full_i;

  // Glyph start clears state and reloads the color
  always_comb begin
    cur = st_q;
    if (glyph_start_i) begin
      cur       = '0;
      cur.phase = PH_IDLE;
      cur.color = start_black_i;
    end
  end

  // High nybble first, then low nybble
  pkd_nybble u_nyb_hi (
    .state_i  (cur),
    .nyb_i    (data_byte_i[7:4]),
    .dyn_i    (dyn_eff),
    .state_o  (mid),
    .tok_vld_o(vld_hi),
    .tok_o    (tok_hi)
  );

  pkd_nybble u_nyb_lo (
    .state_i  (mid),
    .nyb_i    (data_byte_i[3:0]),
    .dyn_i    (dyn_eff),
    .state_o  (st_d),
    .tok_vld_o(vld_lo),
    .tok_o    (tok_lo)
  );

  // Packet build: last_of_byte goes on the final token
  always_comb begin
    q_pkt_o      = '0;
    q_pkt_o.two  = vld_hi & vld_lo;
    q_pkt_o.tok0 = vld_hi ? tok_hi : tok_lo;
    q_pkt_o.tok1 = tok_lo;
    if (vld_hi & vld_lo) q_pkt_o.tok1.last = 1'b1;
    else                 q_pkt_o.tok0.last = 1'b1;
  end

  assign q_push_o = accept & (vld_hi | vld_lo);

  // Decoder state; all-zero is the idle phase, white color
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

endmodule

FILE: src/pkd_fifo.sv
// ============================================================================
// pkd_fifo: two-entry packet queue
// Decouples byte intake from token output.
// ============================================================================
module pkd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pkd_pkg::pkt_t pkt_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          vld_o,
  output pkd_pkg::pkt_t pkt_o
);
  import pkd_pkg::*;

  pkt_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o = (cnt_q == 2'd2);
  assign vld_o  = (cnt_q != 2'd0);
  assign pkt_o  = mem_q[rd_ptr_q];

  // Payload storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= pkt_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: src/pkd_back.sv
// ============================================================================
// pkd_back: token emitter
// Splits queued packets into single token beats behind an output register.
// ============================================================================
module pkd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_vld_i,
  input  pkd_pkg::pkt_t   q_pkt_i,
  output logic            q_pop_o,
  output logic            out_vld_o,
  input  logic            out_rdy_i,
  output pkd_pkg::token_t out_tok_o
);
  import pkd_pkg::*;

  logic   out_vld_q;
  token_t out_tok_q;
  logic   sel_q;
  logic   load;

  assign load      = q_vld_i & (~out_vld_q | out_rdy_i);
  assign q_pop_o   = load & (sel_q | ~q_pkt_i.two);
  assign out_vld_o = out_vld_q;
  assign out_tok_o = out_tok_q;

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) out_tok_q <= sel_q ? q_pkt_i.tok1 : q_pkt_i.tok0;
  end

  // Beat valid and token select within the head packet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      sel_q     <= 1'b0;
    end else begin
      if (load) begin
        out_vld_q <= 1'b1;
        sel_q     <= q_pkt_i.two & ~sel_q;
      end else if (out_rdy_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

endmodule
